// ----- sv/sudiv_pkg.sv -----
`default_nettype none
package sudiv_pkg;

  // Widest operand the block supports; the ports are always this wide.
  localparam int unsigned DW_MAX     = 64;
  localparam int unsigned DATA_W_DEF = 64;

  // One classified division job as it sits in the queue between the
  // front and back parts.
  typedef struct packed {
    logic [DW_MAX-1:0] mag_a;   // dividend magnitude, or raw dividend on divide by zero
    logic [DW_MAX-1:0] mag_b;   // divisor magnitude
    logic              neg_q;   // negate quotient at the end
    logic              neg_r;   // negate remainder at the end
    logic              dbz;     // divisor was zero
  } job_t;

  // Two's complement negation over the full port width.
  function automatic logic [DW_MAX-1:0] neg_full(input logic [DW_MAX-1:0] x);
    neg_full = ~x + DW_MAX'(1);
  endfunction

endpackage
`default_nettype wire

// ----- sv/sudiv_front.sv -----
`default_nettype none
module sudiv_front #(
  parameter int unsigned DATA_WIDTH = sudiv_pkg::DATA_W_DEF
) (
  input  wire logic                      in_mode,
  input  wire logic [63:0]               in_dividend,
  input  wire logic [63:0]               in_divisor,
  output      sudiv_pkg::job_t           job
);
  import sudiv_pkg::*;

  logic [DATA_WIDTH-1:0] a_w;
  logic [DATA_WIDTH-1:0] b_w;
  logic [DW_MAX-1:0]     a_ext;
  logic [DW_MAX-1:0]     b_ext;
  logic [DW_MAX-1:0]     a_neg;
  logic [DW_MAX-1:0]     b_neg;
  logic                  a_sgn;
  logic                  b_sgn;
  logic                  b_zero;

  // Keep only the operand bits that the configured width covers.
  assign a_w   = in_dividend[DATA_WIDTH-1:0];
  assign b_w   = in_divisor[DATA_WIDTH-1:0];
  assign a_ext = DW_MAX'(a_w);
  assign b_ext = DW_MAX'(b_w);

  // Signs count only in signed mode.
  assign a_sgn  = in_mode & a_w[DATA_WIDTH-1];
  assign b_sgn  = in_mode & b_w[DATA_WIDTH-1];
  assign b_zero = (b_w == '0);

  // Magnitudes, masked back to the configured width.
  assign a_neg = DW_MAX'(neg_full(a_ext) & DW_MAX'({DATA_WIDTH{1'b1}}));
  assign b_neg = DW_MAX'(neg_full(b_ext) & DW_MAX'({DATA_WIDTH{1'b1}}));

  // Classify the beat. A zero divisor passes the raw dividend through.
  always_comb begin
    job.dbz   = b_zero;
    job.mag_a = (a_sgn && !b_zero) ? a_neg : a_ext;
    job.mag_b = b_sgn ? b_neg : b_ext;
    job.neg_q = !b_zero && (a_sgn ^ b_sgn);
    job.neg_r = !b_zero && a_sgn;
  end

endmodule
`default_nettype wire

// ----- sv/sudiv_queue.sv -----
`default_nettype none
module sudiv_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sudiv_pkg::job_t push_job,
  output      logic            full,
  input  wire logic            pop,
  output      logic            avail,
  output      sudiv_pkg::job_t head_job
);
  import sudiv_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign avail    = (cnt_r != 2'd0);
  assign head_job = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> avail)
    else $error("queue read while empty");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue fill count out of range");

endmodule
`default_nettype wire

// ----- sv/sudiv_back.sv -----
`default_nettype none
module sudiv_back #(
  parameter int unsigned DATA_WIDTH = sudiv_pkg::DATA_W_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_avail,
  input  wire sudiv_pkg::job_t job,
  output      logic            job_pop,
  output      logic            out_valid,
  input  wire logic            out_stall,
  output      logic [63:0]     out_quotient,
  output      logic [63:0]     out_remainder,
  output      logic            out_divide_by_zero
);
  import sudiv_pkg::*;

  localparam int unsigned CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIX  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] div_r, div_nxt;
  logic                  neg_q_r, neg_q_nxt;
  logic                  neg_r_r, neg_r_nxt;
  logic                  dbz_r, dbz_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [63:0]           out_q_r, out_q_nxt;
  logic [63:0]           out_rem_r, out_rem_nxt;
  logic                  out_dbz_r, out_dbz_nxt;

  logic [DATA_WIDTH:0]   rem_shift;
  logic [DATA_WIDTH:0]   rem_diff;
  logic                  q_bit;
  logic [DW_MAX-1:0]     quo_neg;
  logic [DW_MAX-1:0]     rem_neg;
  logic [DATA_WIDTH-1:0] quo_fix;
  logic [DATA_WIDTH-1:0] rem_fix;
  logic                  out_free;

  // One restoring step: shift in the next dividend bit, trial subtract.
  assign rem_shift = {rem_r, quo_r[DATA_WIDTH-1]};
  assign rem_diff  = rem_shift - {1'b0, div_r};
  assign q_bit     = !rem_diff[DATA_WIDTH];

  // Sign fixup of the finished quotient and remainder.
  assign quo_neg = neg_full(DW_MAX'(quo_r));
  assign rem_neg = neg_full(DW_MAX'(rem_r));
  assign quo_fix = neg_q_r ? quo_neg[DATA_WIDTH-1:0] : quo_r;
  assign rem_fix = neg_r_r ? rem_neg[DATA_WIDTH-1:0] : rem_r;

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: load a job, iterate one quotient bit a cycle (skipped on a zero divisor), then fix signs.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    neg_q_nxt     = neg_q_r;
    neg_r_nxt     = neg_r_r;
    dbz_nxt       = dbz_r;
    out_q_nxt     = out_q_r;
    out_rem_nxt   = out_rem_r;
    out_dbz_nxt   = out_dbz_r;
    out_valid_nxt = out_valid_r && out_stall;
    job_pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (job_avail) begin
          job_pop   = 1'b1;
          div_nxt   = job.mag_b[DATA_WIDTH-1:0];
          neg_q_nxt = job.neg_q;
          neg_r_nxt = job.neg_r;
          dbz_nxt   = job.dbz;
          cnt_nxt   = CW'(DATA_WIDTH - 1);
          if (job.dbz) begin
            quo_nxt   = '1;
            rem_nxt   = job.mag_a[DATA_WIDTH-1:0];
            state_nxt = S_FIX;
          end else begin
            quo_nxt   = job.mag_a[DATA_WIDTH-1:0];
            rem_nxt   = '0;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        quo_nxt = {quo_r[DATA_WIDTH-2:0], q_bit};
        rem_nxt = q_bit ? rem_diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_q_nxt     = 64'(quo_fix);
          out_rem_nxt   = 64'(rem_fix);
          out_dbz_nxt   = dbz_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    neg_q_r   <= neg_q_nxt;
    neg_r_r   <= neg_r_nxt;
    dbz_r     <= dbz_nxt;
    out_q_r   <= out_q_nxt;
    out_rem_r <= out_rem_nxt;
    out_dbz_r <= out_dbz_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_quotient       = out_q_r;
  assign out_remainder      = out_rem_r;
  assign out_divide_by_zero = out_dbz_r;

  a_run_nonzero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (div_r != '0))
    else $error("iteration running with a zero divisor");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX && !dbz_r) |-> (rem_r < div_r))
    else $error("remainder not below divisor after iteration");

  a_dbz_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dbz_r) |-> (out_q_r[DATA_WIDTH-1:0] == '1))
    else $error("divide by zero result without all-ones quotient");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (state_r == S_RUN || state_r == S_FIX))
    else $error("job taken without starting work");

endmodule
`default_nettype wire

// ----- sv/signed_unsigned_divider_64bit.sv -----
// Signed and unsigned integer divider. Each input beat carries a mode, a
// dividend and a divisor; each yields one output beat with quotient,
// remainder and a divide-by-zero flag. Signed mode truncates toward zero and
// gives the remainder the dividend's sign; the most negative value divided
// by minus one wraps. A zero divisor returns an all-ones quotient and the
// dividend as remainder. A front stage classifies each beat into a two-entry
// queue; the back stage retires one quotient bit per cycle in a shared
// compare-subtract unit: it loads a job, runs DATA_WIDTH iterations and then
// fixes the signs, waiting while the stalled output still holds a result.
// A beat with a zero divisor skips the iterations. Up to two further beats
// are accepted while a division is in progress.
`default_nettype none
module signed_unsigned_divider_64bit #(
  parameter int unsigned DATA_WIDTH = sudiv_pkg::DATA_W_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_mode,
  input  wire logic [63:0] in_dividend,
  input  wire logic [63:0] in_divisor,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [63:0] out_quotient,
  output      logic [63:0] out_remainder,
  output      logic        out_divide_by_zero
);
  import sudiv_pkg::*;

  job_t front_job;
  job_t head_job;
  logic q_full;
  logic q_avail;
  logic q_pop;
  logic q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Operand classification.
  sudiv_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .in_mode     (in_mode),
    .in_dividend (in_dividend),
    .in_divisor  (in_divisor),
    .job         (front_job)
  );

  // Decoupling queue.
  sudiv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head_job (head_job)
  );

  // Iterative divider and result register.
  sudiv_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_avail          (q_avail),
    .job                (head_job),
    .job_pop            (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_quotient       (out_quotient),
    .out_remainder      (out_remainder),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule
`default_nettype wire

// ----- verif/signed_unsigned_divider_64bit_tb.sv -----
`default_nettype none
module signed_unsigned_divider_64bit_tb;

  localparam int unsigned W = sudiv_pkg::DW_MAX;

  // Division modes as carried on in_mode.
  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED   = 1'b1;

  localparam logic [W-1:0] MIN_NEG  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_POS  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};

  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES      = 3 * (W + 2);

  typedef enum logic [2:0] {
    PH_DIRECTED,
    PH_HOLD,
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH_IDLE
  } phase_t;

  typedef struct packed {
    logic         mode;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
  } div_op_t;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
    logic         divide_by_zero;
  } div_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic         in_mode = MODE_UNSIGNED;
  logic [W-1:0] in_dividend = '0;
  logic [W-1:0] in_divisor = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_quotient;
  logic [W-1:0] out_remainder;
  logic         out_divide_by_zero;

  div_op_t  pending_ops[$];
  div_res_t expected_results[$];

  phase_t phase = PH_DIRECTED;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  logic   hold_active = 1'b0;

  int divs_offered = 0;
  int divs_accepted = 0;
  int signed_divs = 0;
  int zero_divs = 0;
  int results_checked = 0;
  int error_count = 0;

  signed_unsigned_divider_64bit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_dividend        (in_dividend),
    .in_divisor         (in_divisor),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_quotient       (out_quotient),
    .out_remainder      (out_remainder),
    .out_divide_by_zero (out_divide_by_zero)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected quotient and remainder: restoring division on the magnitudes,
  // then sign fixup. A zero divisor gives all ones and the dividend back.
  function automatic div_res_t divide_expect(input div_op_t op);
    div_res_t     res;
    logic         neg_a;
    logic         neg_b;
    logic         carry;
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W-1:0] quo;
    logic [W-1:0] rem;
    int           i;
    if (op.divisor == '0) begin
      res.quotient       = ALL_ONES;
      res.remainder      = op.dividend;
      res.divide_by_zero = 1'b1;
      return res;
    end
    neg_a = (op.mode == MODE_SIGNED) && op.dividend[W-1];
    neg_b = (op.mode == MODE_SIGNED) && op.divisor[W-1];
    mag_a = neg_a ? -op.dividend : op.dividend;
    mag_b = neg_b ? -op.divisor : op.divisor;
    quo = '0;
    rem = '0;
    for (i = W - 1; i >= 0; i--) begin
      carry = rem[W-1];
      rem = {rem[W-2:0], mag_a[i]};
      quo = {quo[W-2:0], 1'b0};
      if (carry || rem >= mag_b) begin
        rem = rem - mag_b;
        quo[0] = 1'b1;
      end
    end
    if (neg_a != neg_b) quo = -quo;
    if (neg_a) rem = -rem;
    res.quotient       = quo;
    res.remainder      = rem;
    res.divide_by_zero = 1'b0;
    return res;
  endfunction

  function automatic logic [W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Operand mix: full random, scaled magnitudes of both signs, powers of two,
  // tiny values of both signs, and the corner values.
  function automatic logic [W-1:0] rand_operand();
    logic [W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = rand_word();
      4: v = rand_word() >> $urandom_range(W - 1);
      5: v = {{(W-1){1'b0}}, 1'b1} << $urandom_range(W - 1);
      6: v = -(rand_word() >> $urandom_range(W - 1));
      7: v = W'($urandom_range(15));
      8: begin
        case ($urandom_range(4))
          0: v = MIN_NEG;
          1: v = MAX_POS;
          2: v = ALL_ONES;
          3: v = W'(1);
          default: v = '0;
        endcase
      end
      default: v = -(W'($urandom_range(15)));
    endcase
    return v;
  endfunction

  task automatic queue_div(input logic mode, input logic [W-1:0] a, input logic [W-1:0] b);
    div_op_t op;
    op.mode     = mode;
    op.dividend = a;
    op.divisor  = b;
    pending_ops.push_back(op);
  endtask

  task automatic queue_random(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      // Now and then force the wrapping case.
      if ($urandom_range(39) == 0) queue_div(MODE_SIGNED, MIN_NEG, ALL_ONES);
      else queue_div(1'($urandom_range(1)), rand_operand(), rand_operand());
    end
  endtask

  // Hold the sender back until every queued beat is accepted and answered.
  task automatic wait_drained();
    while (pending_ops.size() != 0 || divs_accepted != divs_offered ||
           expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    error_count++;
    $display("result %0d: %s got %h, expected %h", results_checked, field, got, want);
  endtask

  // Input driver: a stalled beat holds; otherwise offer the next op or idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && divs_accepted != divs_offered) begin
      in_valid <= 1'b1;
    end else if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid    <= 1'b1;
      in_mode     <= pending_ops[0].mode;
      in_dividend <= pending_ops[0].dividend;
      in_divisor  <= pending_ops[0].divisor;
      void'(pending_ops.pop_front());
      divs_offered++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output stall driver; the long hold-off overrides the random stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_active) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering.
  initial begin
    wait (phase == PH_HOLD);
    hold_active = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(negedge clk);
    hold_active = 1'b0;
  end

  // Monitor: check an output beat against the oldest expectation first,
  // then record the expectation for an input beat taken at this edge.
  always @(posedge clk) begin
    div_op_t  op;
    div_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("unexpected result beat: quotient %h remainder %h", out_quotient,
                   out_remainder);
        end else begin
          want = expected_results.pop_front();
          if (out_quotient !== want.quotient)
            report_mismatch("quotient", out_quotient, want.quotient);
          if (out_remainder !== want.remainder)
            report_mismatch("remainder", out_remainder, want.remainder);
          if (out_divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", W'(out_divide_by_zero),
                            W'(want.divide_by_zero));
        end
        results_checked++;
      end
      if (in_valid && !in_stall) begin
        op.mode     = in_mode;
        op.dividend = in_dividend;
        op.divisor  = in_divisor;
        expected_results.push_back(divide_expect(op));
        divs_accepted++;
        if (in_mode == MODE_SIGNED) signed_divs++;
        if (in_divisor == '0) zero_divs++;
      end
    end
  end

  // Stimulus phases.
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners in both modes, back to back.
    phase = PH_DIRECTED;
    queue_div(MODE_UNSIGNED, '0, W'(1));
    queue_div(MODE_UNSIGNED, ALL_ONES, W'(1));
    queue_div(MODE_UNSIGNED, ALL_ONES, ALL_ONES);
    queue_div(MODE_UNSIGNED, ALL_ONES, '0);
    queue_div(MODE_UNSIGNED, '0, '0);
    queue_div(MODE_UNSIGNED, W'(100), W'(7));
    queue_div(MODE_UNSIGNED, W'(1), ALL_ONES);
    queue_div(MODE_UNSIGNED, MIN_NEG, W'(2));
    queue_div(MODE_UNSIGNED, MIN_NEG, ALL_ONES);
    queue_div(MODE_UNSIGNED, W'(5), '0);
    queue_div(MODE_SIGNED, MIN_NEG, ALL_ONES);
    queue_div(MODE_SIGNED, MIN_NEG, W'(1));
    queue_div(MODE_SIGNED, -W'(7), W'(2));
    queue_div(MODE_SIGNED, W'(7), -W'(2));
    queue_div(MODE_SIGNED, -W'(7), -W'(2));
    queue_div(MODE_SIGNED, W'(7), W'(2));
    queue_div(MODE_SIGNED, MIN_NEG, MIN_NEG);
    queue_div(MODE_SIGNED, MAX_POS, ALL_ONES);
    queue_div(MODE_SIGNED, MAX_POS, MIN_NEG);
    queue_div(MODE_SIGNED, ALL_ONES, '0);
    queue_div(MODE_SIGNED, MIN_NEG, '0);
    queue_div(MODE_SIGNED, '0, ALL_ONES);
    queue_div(MODE_SIGNED, ALL_ONES, MIN_NEG);
    queue_div(MODE_SIGNED, MIN_NEG, W'(2));
    wait_drained();

    // Receiver holds off while the sender fills the block.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    phase = PH_HOLD;
    queue_random(40);
    wait_drained();

    phase = PH_FREE;
    queue_random(190);
    wait_drained();

    phase = PH_SEND_IDLE;
    send_idle_pct  = 75;
    recv_stall_pct = 0;
    queue_random(190);
    wait_drained();

    phase = PH_RECV_STALL;
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    queue_random(190);
    wait_drained();

    phase = PH_BOTH_IDLE;
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    queue_random(190);
    wait_drained();

    // Let any stray beat show up before the verdict.
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d divisions (%0d signed, %0d by zero) over six idle/stall phases,",
             divs_accepted, signed_divs, zero_divs);
    $display("including a %0d-cycle output hold-off; %0d results checked.",
             LONG_HOLD_CYCLES, results_checked);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("signed_unsigned_divider_64bit: match");
    end else begin
      $display("signed_unsigned_divider_64bit: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("signed_unsigned_divider_64bit: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
sv/sudiv_pkg.sv
sv/sudiv_front.sv
sv/sudiv_queue.sv
sv/sudiv_back.sv
sv/signed_unsigned_divider_64bit.sv
verif/signed_unsigned_divider_64bit_tb.sv
